// ===== hdl/sexd_pkg.sv =====
// ----------------------------------------------------------------------------
// sexd_pkg
// Types, character codes and helpers shared by the s-expression token decoder.
// ----------------------------------------------------------------------------
package sexd_pkg;

  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_END   = 3'd1,
    EV_OPEN  = 3'd2,
    EV_CLOSE = 3'd3,
    EV_ERROR = 3'd4
  } sexd_event_t;

  typedef enum logic [2:0] {
    ERR_PAREN     = 3'd0,
    ERR_BAD_CHAR  = 3'd1,
    ERR_BAD_HEX   = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_BAD_DIGIT = 3'd4,
    ERR_BAD_ESC   = 3'd5,
    ERR_DEPTH     = 3'd6
  } sexd_error_t;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;

  // printable range and decimal escape limits
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd127;
  localparam logic [9:0] DEC_HUNDRED = 10'd100;
  localparam logic [9:0] DEC_TEN     = 10'd10;
  localparam logic [9:0] BYTE_LIMIT  = 10'd256;

  typedef struct packed {
    logic       in_str;
    logic [1:0] esc_len;
    logic [7:0] lead;
    logic [7:0] second;
  } sexd_state_t;

  typedef struct packed {
    logic        valid;
    sexd_event_t kind;
    logic [7:0]  data;
    logic        top;
    sexd_error_t code;
    logic [9:0]  detail;
  } sexd_result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (is_dec(c)) begin
      d = 4'(c - 8'h30);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = 4'(c - 8'h41 + 8'd10);
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = 4'(c - 8'h61 + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== hdl/sexd_step.sv =====
// ----------------------------------------------------------------------------
// sexd_step
// Per-byte decode: next tokenizer state and at most one event for one byte.
// ----------------------------------------------------------------------------
module sexd_step import sexd_pkg::*; #(
  parameter int MAX_DEPTH = 64,
  parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
  input  logic [7:0]    c,
  input  sexd_state_t   st,
  input  logic [DW-1:0] depth,
  output sexd_state_t   st_nxt,
  output logic [DW-1:0] depth_nxt,
  output sexd_result_t  res
);

  logic [9:0] lead_hund;
  logic [9:0] c_hund;
  logic [9:0] val2;
  logic [9:0] val3;

  assign lead_hund = 10'(digit_value(st.lead)) * DEC_HUNDRED;
  assign c_hund    = 10'(digit_value(c)) * DEC_HUNDRED;
  assign val2      = lead_hund + 10'(digit_value(c)) * DEC_TEN;
  assign val3      = lead_hund + 10'(digit_value(st.second)) * DEC_TEN
                     + 10'(digit_value(c));

  always_comb begin
    st_nxt     = st;
    depth_nxt  = depth;
    res.valid  = 1'b0;
    res.kind   = EV_DATA;
    res.data   = 8'd0;
    res.top    = 1'b0;
    res.code   = ERR_PAREN;
    res.detail = 10'd0;

    if (!st.in_str) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        // whitespace, no event
      end else if (c == CH_QUOTE) begin
        st_nxt.in_str  = 1'b1;
        st_nxt.esc_len = 2'd0;
      end else if (c == CH_OPEN) begin
        res.valid = 1'b1;
        if (depth >= DW'(MAX_DEPTH)) begin
          res.kind   = EV_ERROR;
          res.code   = ERR_DEPTH;
          res.detail = 10'(c);
        end else begin
          res.kind  = EV_OPEN;
          depth_nxt = depth + DW'(1);
        end
      end else if (c == CH_CLOSE) begin
        res.valid = 1'b1;
        if (depth == DW'(0)) begin
          res.kind   = EV_ERROR;
          res.code   = ERR_PAREN;
          res.detail = 10'(c);
        end else begin
          res.kind  = EV_CLOSE;
          res.top   = (depth == DW'(1));
          depth_nxt = depth - DW'(1);
        end
      end else begin
        res.valid  = 1'b1;
        res.kind   = EV_ERROR;
        res.code   = ERR_BAD_CHAR;
        res.detail = 10'(c);
      end
    end else begin
      case (st.esc_len)
        2'd0: begin
          if (c == CH_BSLASH) begin
            st_nxt.esc_len = 2'd1;
          end else if (c == CH_QUOTE) begin
            st_nxt.in_str = 1'b0;
            res.valid     = 1'b1;
            res.kind      = EV_END;
            res.top       = (depth == DW'(0));
          end else begin
            res.valid = 1'b1;
            res.data  = c;
          end
        end
        2'd1: begin
          res.valid      = 1'b1;
          st_nxt.esc_len = 2'd0;
          if (c == CH_LOW_N) begin
            res.data = CH_LF;
          end else if (c == CH_LOW_T) begin
            res.data = CH_TAB;
          end else if (c == CH_LOW_R) begin
            res.data = CH_CR;
          end else if (c == CH_LOW_B) begin
            res.data = CH_BS;
          end else if (c == CH_BSLASH || c == CH_QUOTE || c == CH_APOS || c == CH_SPACE) begin
            res.data = c;
          end else if (c == CH_LOW_X || c == CH_ZERO || c == CH_ONE || c == CH_TWO) begin
            // start of a hex or decimal escape
            res.valid      = 1'b0;
            st_nxt.lead    = c;
            st_nxt.esc_len = 2'd2;
          end else if (is_dec(c)) begin
            st_nxt.esc_len = st.esc_len;
            res.kind       = EV_ERROR;
            res.code       = ERR_RANGE;
            res.detail     = c_hund;
          end else if (c < PRINT_LO || c >= PRINT_HI) begin
            st_nxt.esc_len = st.esc_len;
            res.kind       = EV_ERROR;
            res.code       = ERR_BAD_ESC;
            res.detail     = 10'(c);
          end else begin
            res.data = c;
          end
        end
        2'd2: begin
          if (st.lead == CH_LOW_X) begin
            if (!is_hex(c)) begin
              res.valid  = 1'b1;
              res.kind   = EV_ERROR;
              res.code   = ERR_BAD_HEX;
              res.detail = 10'(c);
            end else begin
              st_nxt.second  = c;
              st_nxt.esc_len = 2'd3;
            end
          end else if (!is_dec(c)) begin
            res.valid  = 1'b1;
            res.kind   = EV_ERROR;
            res.code   = ERR_BAD_DIGIT;
            res.detail = 10'(c);
          end else if (val2 >= BYTE_LIMIT) begin
            res.valid  = 1'b1;
            res.kind   = EV_ERROR;
            res.code   = ERR_RANGE;
            res.detail = val2;
          end else begin
            st_nxt.second  = c;
            st_nxt.esc_len = 2'd3;
          end
        end
        default: begin
          res.valid = 1'b1;
          if (st.lead == CH_LOW_X) begin
            if (is_hex(st.second) && is_hex(c)) begin
              res.data       = {digit_value(st.second), digit_value(c)};
              st_nxt.esc_len = 2'd0;
            end else begin
              res.kind   = EV_ERROR;
              res.code   = ERR_BAD_HEX;
              res.detail = 10'(c);
            end
          end else if (is_dec(st.second) && is_dec(c)) begin
            if (val3 < BYTE_LIMIT) begin
              res.data       = val3[7:0];
              st_nxt.esc_len = 2'd0;
            end else begin
              res.kind   = EV_ERROR;
              res.code   = ERR_RANGE;
              res.detail = val3;
            end
          end else begin
            res.kind   = EV_ERROR;
            res.code   = ERR_BAD_DIGIT;
            res.detail = 10'(c);
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/sexpr_token_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_stream_decoder
// Tokenizer for a parenthesized text format with string escape decoding.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_stall       in_byte
//  out      out_valid / out_stall     out_event_kind, out_byte, out_top_level,
//                                     out_error_code, out_error_detail
//
//  one byte per cycle while nothing stalls; a byte is captured in the input
//  register, and its event is then registered in the output register
//  the decode between the two registers is a single pass with no loop
//  rst_n (synchronous) clears both valid flags, string/escape state and depth
//  out_stall holds the output register; the input register then holds too and
//  in_stall rises while it is full
// ----------------------------------------------------------------------------
module sexpr_token_stream_decoder import sexd_pkg::*; #(
  parameter int MAX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_byte,
  output logic       out_top_level,
  output logic [2:0] out_error_code,
  output logic [9:0] out_error_detail
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  sexd_state_t   st_r;
  sexd_state_t   st_nxt;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  sexd_result_t  res;
  sexd_result_t  out_r;
  logic          out_free;
  logic          fire;

  sexd_step #(
    .MAX_DEPTH(MAX_DEPTH),
    .DW       (DW)
  ) u_step (
    .c        (in_byte_r),
    .st       (st_r),
    .depth    (depth_r),
    .st_nxt   (st_nxt),
    .depth_nxt(depth_nxt),
    .res      (res)
  );

  assign out_free = !out_r.valid || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_r.valid    <= 1'b0;
      st_r.in_str    <= 1'b0;
      st_r.esc_len   <= 2'd0;
      depth_r        <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        st_r.in_str  <= st_nxt.in_str;
        st_r.esc_len <= st_nxt.esc_len;
        depth_r      <= depth_nxt;
      end
      if (out_free) begin
        out_r.valid <= fire && res.valid;
      end
    end

    // payload registers, no reset
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
    end
    if (fire) begin
      st_r.lead   <= st_nxt.lead;
      st_r.second <= st_nxt.second;
    end
    if (fire && res.valid) begin
      out_r.kind   <= res.kind;
      out_r.data   <= res.data;
      out_r.top    <= res.top;
      out_r.code   <= res.code;
      out_r.detail <= res.detail;
    end
  end

  assign out_valid        = out_r.valid;
  assign out_event_kind   = out_r.kind;
  assign out_byte         = out_r.data;
  assign out_top_level    = out_r.top;
  assign out_error_code   = out_r.code;
  assign out_error_detail = out_r.detail;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_DEPTH))
    else $error("nesting depth above limit");

  a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc_len != 2'd0 |-> st_r.in_str)
    else $error("escape pending outside a string");

  a_top_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_r.valid && out_r.top |-> (out_r.kind == EV_END || out_r.kind == EV_CLOSE))
    else $error("top-level flag on wrong event");

  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r != $past(depth_r) |->
      (depth_r == $past(depth_r) + DW'(1) || depth_r == $past(depth_r) - DW'(1)))
    else $error("depth moved by more than one");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> depth_r == $past(depth_r) && st_r.in_str == $past(st_r.in_str))
    else $error("state changed without a processed request");

endmodule

// ===== tb/sexpr_token_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_token_stream_decoder_tb
// Drives byte streams of parenthesized text into the decoder and compares
// every token event against a cycle-free decode of the same bytes.
// ----------------------------------------------------------------------------
module sexpr_token_stream_decoder_tb;
  import sexd_pkg::*;

  localparam int DEPTH_LIMIT = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_kind;
  logic [7:0] out_byte;
  logic       out_top_level;
  logic [2:0] out_error_code;
  logic [9:0] out_error_detail;

  int   n_accepted = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic holding = 1'b0;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       top;
    logic [2:0] code;
    logic [9:0] detail;
  } token_event_t;

  class token_scoreboard;
    token_event_t pending_tokens[$];
    int           n_fail;
    logic         in_string;
    logic [1:0]   esc_len;
    logic [7:0]   lead;
    logic [7:0]   second;
    int           depth;

    function new();
      n_fail    = 0;
      in_string = 1'b0;
      esc_len   = 2'd0;
      lead      = 8'h00;
      second    = 8'h00;
      depth     = 0;
    endfunction

    function bit is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= 8'h39);
    endfunction

    function bit is_hexit(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function int digit_of(input logic [7:0] c);
      if (is_digit(c)) return c - CH_ZERO;
      if ((c >= 8'h41) && (c <= 8'h46)) return c - 8'h41 + 10;
      if ((c >= 8'h61) && (c <= 8'h66)) return c - 8'h61 + 10;
      return 0;
    endfunction

    function token_event_t token(input logic [2:0] kind, input logic [7:0] data,
                                 input logic top, input logic [2:0] code, input int detail);
      token_event_t t;
      t.kind   = kind;
      t.data   = data;
      t.top    = top;
      t.code   = code;
      t.detail = 10'(detail);
      return t;
    endfunction

    function token_event_t fault(input logic [2:0] code, input int detail);
      return token(EV_ERROR, 8'h00, 1'b0, code, detail);
    endfunction

    // a decoded data byte always closes any escape in progress
    function token_event_t plain(input logic [7:0] b);
      esc_len = 2'd0;
      return token(EV_DATA, b, 1'b0, ERR_PAREN, 0);
    endfunction

    function bit decode_byte(input logic [7:0] c, output token_event_t ev);
      int v;
      ev = token(EV_DATA, 8'h00, 1'b0, ERR_PAREN, 0);
      if (!in_string) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return 1'b0;
        if (c == CH_QUOTE) begin
          in_string = 1'b1;
          esc_len   = 2'd0;
          return 1'b0;
        end
        if (c == CH_OPEN) begin
          if (depth >= DEPTH_LIMIT) begin
            ev = fault(ERR_DEPTH, c);
          end else begin
            depth++;
            ev = token(EV_OPEN, 8'h00, 1'b0, ERR_PAREN, 0);
          end
          return 1'b1;
        end
        if (c == CH_CLOSE) begin
          if (depth == 0) begin
            ev = fault(ERR_PAREN, c);
          end else begin
            depth--;
            ev = token(EV_CLOSE, 8'h00, depth == 0, ERR_PAREN, 0);
          end
          return 1'b1;
        end
        ev = fault(ERR_BAD_CHAR, c);
        return 1'b1;
      end
      // errors inside an escape leave the prefix in place
      case (esc_len)
        2'd0: begin
          if (c == CH_BSLASH) begin
            esc_len = 2'd1;
            return 1'b0;
          end
          if (c == CH_QUOTE) begin
            in_string = 1'b0;
            ev = token(EV_END, 8'h00, depth == 0, ERR_PAREN, 0);
            return 1'b1;
          end
          ev = plain(c);
        end
        2'd1: begin
          case (c)
            CH_LOW_N: ev = plain(CH_LF);
            CH_LOW_T: ev = plain(CH_TAB);
            CH_LOW_R: ev = plain(CH_CR);
            CH_LOW_B: ev = plain(CH_BS);
            CH_BSLASH, CH_QUOTE, CH_APOS, CH_SPACE: ev = plain(c);
            CH_LOW_X, CH_ZERO, CH_ONE, CH_TWO: begin
              lead    = c;
              esc_len = 2'd2;
              return 1'b0;
            end
            default: begin
              if (is_digit(c)) begin
                ev = fault(ERR_RANGE, digit_of(c) * 100);
              end else if (c < PRINT_LO || c >= PRINT_HI) begin
                ev = fault(ERR_BAD_ESC, c);
              end else begin
                ev = plain(c);
              end
            end
          endcase
        end
        2'd2: begin
          if (lead == CH_LOW_X) begin
            if (!is_hexit(c)) begin
              ev = fault(ERR_BAD_HEX, c);
              return 1'b1;
            end
          end else begin
            v = digit_of(lead) * 100 + digit_of(c) * 10;
            if (!is_digit(c)) begin
              ev = fault(ERR_BAD_DIGIT, c);
              return 1'b1;
            end
            if (v >= 256) begin
              ev = fault(ERR_RANGE, v);
              return 1'b1;
            end
          end
          second  = c;
          esc_len = 2'd3;
          return 1'b0;
        end
        default: begin
          if (lead == CH_LOW_X) begin
            if (is_hexit(second) && is_hexit(c)) begin
              ev = plain(8'(digit_of(second) * 16 + digit_of(c)));
            end else begin
              ev = fault(ERR_BAD_HEX, c);
            end
          end else if (is_digit(second) && is_digit(c)) begin
            v = digit_of(lead) * 100 + digit_of(second) * 10 + digit_of(c);
            if (v < 256) begin
              ev = plain(8'(v));
            end else begin
              ev = fault(ERR_RANGE, v);
            end
          end else begin
            ev = fault(ERR_BAD_DIGIT, c);
          end
        end
      endcase
      return 1'b1;
    endfunction

    function void flag(input string msg);
      n_fail++;
      if (n_fail <= 10) $display("%s", msg);
    endfunction

    function void note_request(input logic [7:0] c);
      token_event_t ev;
      if (decode_byte(c, ev)) pending_tokens = {pending_tokens, ev};
    endfunction

    function void check_result(input token_event_t got);
      token_event_t want;
      if (pending_tokens.size() == 0) begin
        flag($sformatf("unexpected event kind=%0d byte=%02h top=%0b code=%0d detail=%0d",
                       got.kind, got.data, got.top, got.code, got.detail));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.top !== want.top ||
          got.code !== want.code || got.detail !== want.detail) begin
        flag($sformatf({"event mismatch: expected kind=%0d byte=%02h top=%0b code=%0d ",
                        "detail=%0d, got kind=%0d byte=%02h top=%0b code=%0d detail=%0d"},
                       want.kind, want.data, want.top, want.code, want.detail,
                       got.kind, got.data, got.top, got.code, got.detail));
      end
    endfunction

    function void close_out();
      if (pending_tokens.size() != 0)
        flag($sformatf("%0d expected events never arrived", pending_tokens.size()));
    endfunction
  endclass

  token_scoreboard sb = new();

  sexpr_token_stream_decoder #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_kind(out_event_kind),
    .out_byte(out_byte),
    .out_top_level(out_top_level),
    .out_error_code(out_error_code),
    .out_error_detail(out_error_detail)
  );

  always #5 clk = ~clk;

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b);
    n_accepted++;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(7))
      0: return CH_LOW_N;
      1: return CH_LOW_T;
      2: return CH_LOW_R;
      3: return CH_LOW_B;
      4: return CH_BSLASH;
      5: return CH_QUOTE;
      6: return CH_APOS;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + d - 10);
  endfunction

  // string content byte: mostly printable, sometimes control or high bytes
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = ($urandom_range(99) < 85) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
    if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
    return c;
  endfunction

  task automatic send_space();
    repeat ($urandom_range(2)) send_byte(blank_char());
  endtask

  task automatic send_escape();
    int kind;
    int v;
    kind = $urandom_range(99);
    v    = $urandom_range(255);
    send_byte(CH_BSLASH);
    if (kind < 25) begin
      send_byte(simple_escape());
    end else if (kind < 45) begin
      send_byte(CH_LOW_X);
      send_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : hex_char(v / 16));
      send_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : hex_char(v % 16));
    end else if (kind < 65) begin
      send_byte(8'(CH_ZERO + v / 100));
      send_byte(8'(CH_ZERO + (v / 10) % 10));
      send_byte(8'(CH_ZERO + v % 10));
    end else if (kind < 75) begin
      send_byte(8'($urandom_range(8'h41, 8'h5A)));
    end else if (kind < 85) begin
      // decimal with random digits, may overflow or hit a non-digit
      send_byte(8'(CH_ZERO + $urandom_range(2)));
      repeat (2)
        send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                           : 8'(CH_ZERO + $urandom_range(9)));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic send_string();
    int n;
    send_byte(CH_QUOTE);
    n = $urandom_range(6);
    repeat (n) begin
      if ($urandom_range(99) < 55) begin
        send_byte(plain_char());
      end else begin
        send_escape();
      end
    end
    send_byte(CH_QUOTE);
  endtask

  task automatic send_value(input int level);
    int n;
    if (level < 3 && $urandom_range(99) < 40) begin
      send_byte(CH_OPEN);
      n = $urandom_range(4);
      repeat (n) begin
        send_space();
        send_value(level + 1);
      end
      send_space();
      send_byte(CH_CLOSE);
    end else begin
      send_string();
    end
  endtask

  task automatic random_chunk();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      send_value(0);
      send_space();
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    end else begin
      send_byte($urandom_range(1) ? CH_OPEN : CH_CLOSE);
    end
  endtask

  // result side: accept, check, then pick the next stall
  initial begin
    token_event_t seen;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen.kind   = out_event_kind;
        seen.data   = out_byte;
        seen.top    = out_top_level;
        seen.code   = out_error_code;
        seen.detail = out_error_detail;
        sb.check_result(seen);
      end
      out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long hold-off while the sender keeps offering, so the input backs up
  initial begin
    wait (n_accepted >= 430);
    @(posedge clk);
    holding <= 1'b1;
    repeat (300) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] primer[$];
    int         base;
    primer = '{CH_SPACE, CH_LF, CH_CLOSE, 8'h00, 8'hFF, CH_OPEN, CH_QUOTE, 8'hFF, 8'h00,
               CH_BSLASH, 8'h39, 8'h01, 8'hFF, 8'h7E,
               CH_BSLASH, CH_LOW_X, 8'h47, 8'h66, 8'h46,
               CH_BSLASH, CH_TWO, 8'h36, 8'h35, 8'h36, 8'h35,
               CH_QUOTE, CH_CLOSE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 54;
    foreach (primer[i]) send_byte(primer[i]);
    base = n_accepted;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 36 : (p == 1) ? 54 : 0;
      recv_idle_pct = (p == 0) ? 54 : (p == 1) ? 36 : 0;
      if (p == 0) begin
        // nest past the limit, then unwind past zero
        repeat (DEPTH_LIMIT + 2) send_byte(CH_OPEN);
        repeat (DEPTH_LIMIT + 2) send_byte(CH_CLOSE);
      end
      while (n_accepted < base + 170 * (p + 1)) random_chunk();
    end
    in_valid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.n_fail == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
